@@ hdl/bkd_pkg.sv @@
// Package for the bech32 key decoder: transaction types, queue entry type,
// alphabet and checksum constants, polymod step function. No dependencies.
`timescale 1ns / 1ps

package bkd_pkg;

	typedef struct packed {
		logic [7:0] symbol_char;
		logic       is_final;
	} in_item_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       decode_ok;
		logic       end_of_run;
	} out_item_t;

	// Classified character passed from the front end to the back end.
	typedef struct packed {
		logic [4:0] sym;
		logic       err;
		logic       chk_en;
		logic       grp_en;
		logic       fin;
		logic       len_ok;
	} entry_t;

	localparam int unsigned KEY_LEN       = 63;
	localparam int unsigned DATA_SYMS     = 52;
	localparam int unsigned PAYLOAD_BYTES = 32;
	localparam int unsigned PREFIX_LEN    = 4;
	localparam int unsigned HDR_LEN       = PREFIX_LEN + 1;

	localparam logic [6:0] POS_MAX      = 7'd127;
	localparam logic [6:0] POS_SEP      = 7'(PREFIX_LEN);
	localparam logic [6:0] POS_DATA_END = 7'(HDR_LEN + DATA_SYMS);
	localparam logic [6:0] POS_LAST     = 7'(KEY_LEN - 1);
	localparam logic [6:0] POS_END      = 7'(KEY_LEN);

	localparam logic [7:0] SEP_CHAR = 8'h31;
	localparam logic [7:0] UPPER_A  = 8'h41;
	localparam logic [7:0] UPPER_Z  = 8'h5a;
	localparam logic [7:0] CASE_OFS = 8'h20;

	localparam logic [7:0] KEY_PREFIX [PREFIX_LEN] = '{8'h6e, 8'h70, 8'h75, 8'h62};

	localparam logic [7:0] ALPHABET [32] = '{
		8'h71, 8'h70, 8'h7a, 8'h72, 8'h79, 8'h39, 8'h78, 8'h38,
		8'h67, 8'h66, 8'h32, 8'h74, 8'h76, 8'h64, 8'h77, 8'h30,
		8'h73, 8'h33, 8'h6a, 8'h6e, 8'h35, 8'h34, 8'h6b, 8'h68,
		8'h63, 8'h65, 8'h36, 8'h6d, 8'h75, 8'h61, 8'h37, 8'h6c
	};

	localparam logic [29:0] GEN_POLY [5] = '{
		30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
	};

	localparam logic [29:0] CHK_GOOD = 30'd1;

	function automatic logic [29:0] poly_step(input logic [29:0] chk, input logic [4:0] v);
		logic [4:0]  top;
		logic [29:0] r;
		top = chk[29:25];
		r = {chk[24:0], v};
		for (int j = 0; j < 5; j++) begin
			if (top[j]) begin
				r = r ^ GEN_POLY[j];
			end
		end
		return r;
	endfunction

	// Checksum after the expanded human-readable part.
	function automatic logic [29:0] prefix_chk();
		logic [29:0] c;
		c = 30'd1;
		for (int i = 0; i < PREFIX_LEN; i++) begin
			c = poly_step(c, {2'b00, KEY_PREFIX[i][7:5]});
		end
		c = poly_step(c, 5'd0);
		for (int i = 0; i < PREFIX_LEN; i++) begin
			c = poly_step(c, KEY_PREFIX[i][4:0]);
		end
		return c;
	endfunction

	localparam logic [29:0] PREFIX_CHK = prefix_chk();

	// Returns {found, value}.
	function automatic logic [5:0] sym_lookup(input logic [7:0] c);
		logic [5:0] r;
		r = 6'd0;
		for (int i = 0; i < 32; i++) begin
			if (ALPHABET[i] == c) begin
				r = {1'b1, 5'(i)};
			end
		end
		return r;
	endfunction

endpackage

@@ hdl/bkd_front.sv @@
// Front end of the bech32 key decoder: folds case, tracks position, classifies.
// Depends on bkd_pkg.
`timescale 1ns / 1ps

module bkd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              char_valid,
	output logic              char_ready,
	input  bkd_pkg::in_item_t char_item,
	output logic              push_valid,
	input  logic              push_ready,
	output bkd_pkg::entry_t   push_entry
);

	logic [6:0] pos_q;
	logic [7:0] c;
	logic [5:0] lk;

	assign char_ready = push_ready;
	assign push_valid = char_valid;

	always_comb begin
		c = char_item.symbol_char;
		if (c >= bkd_pkg::UPPER_A && c <= bkd_pkg::UPPER_Z) begin
			c = c + bkd_pkg::CASE_OFS;
		end
		lk = bkd_pkg::sym_lookup(c);
		push_entry        = '0;
		push_entry.sym    = lk[4:0];
		push_entry.fin    = char_item.is_final;
		push_entry.len_ok = (pos_q == bkd_pkg::POS_LAST);
		if (pos_q < bkd_pkg::POS_SEP) begin
			push_entry.err = (c != bkd_pkg::KEY_PREFIX[pos_q[1:0]]);
		end else if (pos_q == bkd_pkg::POS_SEP) begin
			push_entry.err = (c != bkd_pkg::SEP_CHAR);
		end else if (pos_q < bkd_pkg::POS_END) begin
			push_entry.err    = !lk[5];
			push_entry.chk_en = lk[5];
			push_entry.grp_en = lk[5] && (pos_q < bkd_pkg::POS_DATA_END);
		end else begin
			push_entry.err = 1'b1;
		end
	end

	// Advance the position per transaction; restart after the final character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (char_valid && push_ready) begin
			if (char_item.is_final) begin
				pos_q <= '0;
			end else if (pos_q != bkd_pkg::POS_MAX) begin
				pos_q <= pos_q + 7'd1;
			end
		end
	end

endmodule

@@ hdl/bkd_fifo.sv @@
// Two-entry queue of classified characters between front and back end.
// Depends on bkd_pkg.
`timescale 1ns / 1ps

module bkd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  bkd_pkg::entry_t push_entry,
	output logic            pop_valid,
	input  logic            pop_ready,
	output bkd_pkg::entry_t pop_entry
);

	bkd_pkg::entry_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_entry  = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

@@ hdl/bkd_back.sv @@
// Back end of the bech32 key decoder: checksum, 5-to-8 bit regrouping,
// payload store and result emission. Depends on bkd_pkg.
`timescale 1ns / 1ps

module bkd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  bkd_pkg::entry_t    pop_entry,
	output logic               res_valid,
	input  logic               res_ready,
	output bkd_pkg::out_item_t res_item
);

	typedef enum logic [1:0] {
		ST_RUN  = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t      state_q;
	logic [29:0] chk_q;
	logic [11:0] acc_q;
	logic [3:0]  bc_q;
	logic [5:0]  bytes_q;
	logic        err_q;
	logic [4:0]  rd_ptr_q;
	logic [7:0]  store_q [bkd_pkg::PAYLOAD_BYTES];

	logic        v_s1;
	logic        err_s1;
	logic        last_s1;
	logic [7:0]  rdata_s1;

	logic               out_valid_q;
	bkd_pkg::out_item_t out_q;

	logic        adv;
	logic        consume;
	logic        emitting;
	logic [29:0] chk_n;
	logic [11:0] acc_n;
	logic [3:0]  bc_sum;
	logic [3:0]  bc_n;
	logic [5:0]  bytes_n;
	logic        err_n;
	logic        wr_en;
	logic [7:0]  wr_byte;
	logic [11:0] pad_mask;
	logic        accept;
	logic        issue_err;

	assign adv      = !out_valid_q || res_ready;
	assign emitting = (state_q == ST_EMIT);
	assign pop_ready = !emitting && (!pop_entry.fin || adv);
	assign consume  = pop_valid && pop_ready;

	always_comb begin
		chk_n   = pop_entry.chk_en ? bkd_pkg::poly_step(chk_q, pop_entry.sym) : chk_q;
		acc_n   = acc_q;
		bc_sum  = bc_q + 4'd5;
		bc_n    = bc_q;
		bytes_n = bytes_q;
		err_n   = err_q || pop_entry.err;
		wr_en   = 1'b0;
		if (pop_entry.grp_en) begin
			acc_n = {acc_q[6:0], pop_entry.sym};
			bc_n  = bc_sum;
			if (bc_sum[3]) begin
				bc_n = bc_sum - 4'd8;
				if (bytes_q < 6'(bkd_pkg::PAYLOAD_BYTES)) begin
					wr_en   = 1'b1;
					bytes_n = bytes_q + 6'd1;
				end else begin
					err_n = 1'b1;
				end
			end
		end
		wr_byte  = 8'(acc_n >> bc_n);
		pad_mask = (12'd1 << bc_n) - 12'd1;
		accept   = !err_n && pop_entry.len_ok && (chk_n == bkd_pkg::CHK_GOOD) &&
			(bytes_n == 6'(bkd_pkg::PAYLOAD_BYTES)) && (bc_n < 4'd5) &&
			((acc_n & pad_mask) == 12'd0);
		issue_err = consume && pop_entry.fin && !accept;
	end

	// Payload store: one write port, registered read.
	always_ff @(posedge clk) begin
		if (consume && wr_en) begin
			store_q[bytes_q[4:0]] <= wr_byte;
		end
		if (adv) begin
			rdata_s1 <= store_q[rd_ptr_q];
		end
		if (adv && v_s1) begin
			out_q.data_byte  <= err_s1 ? 8'd0 : rdata_s1;
			out_q.decode_ok  <= !err_s1;
			out_q.end_of_run <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_RUN;
			chk_q       <= bkd_pkg::PREFIX_CHK;
			acc_q       <= '0;
			bc_q        <= '0;
			bytes_q     <= '0;
			err_q       <= 1'b0;
			rd_ptr_q    <= '0;
			v_s1        <= 1'b0;
			err_s1      <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= v_s1;
				v_s1        <= emitting || issue_err;
				err_s1      <= !emitting;
				last_s1     <= !emitting || (rd_ptr_q == 5'(bkd_pkg::PAYLOAD_BYTES - 1));
			end
			unique case (state_q)
				ST_RUN: begin
					if (consume) begin
						if (pop_entry.fin) begin
							chk_q   <= bkd_pkg::PREFIX_CHK;
							acc_q   <= '0;
							bc_q    <= '0;
							bytes_q <= '0;
							err_q   <= 1'b0;
							if (accept) begin
								state_q  <= ST_EMIT;
								rd_ptr_q <= '0;
							end
						end else begin
							chk_q   <= chk_n;
							acc_q   <= acc_n;
							bc_q    <= bc_n;
							bytes_q <= bytes_n;
							err_q   <= err_n;
						end
					end
				end
				ST_EMIT: begin
					if (adv) begin
						rd_ptr_q <= rd_ptr_q + 5'd1;
						if (rd_ptr_q == 5'(bkd_pkg::PAYLOAD_BYTES - 1)) begin
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	assign res_valid = out_valid_q;
	assign res_item  = out_q;

endmodule

@@ hdl/bech32_key_decoder_core.sv @@
// Top level of the bech32 key decoder: front end, queue and back end.
// Depends on bkd_pkg, bkd_front, bkd_fifo, bkd_back.
`timescale 1ns / 1ps

// Decodes a bech32 "npub" key string, one character per char transaction,
// into 32 payload bytes. Letters are folded to lower case, so upper, lower
// and mixed case strings all decode. A character with is_final set closes
// the string: if it was exactly 63 characters long, started with "npub1",
// held only alphabet symbols, had a checksum of 1 and zero padding, the
// block returns 32 res transactions with decode_ok set and end_of_run on
// the last; otherwise it returns a single transaction with data_byte 0,
// decode_ok 0 and end_of_run 1. Non-final characters return nothing.
// Throughput: one character per cycle while a string loads, unless the
// queue is full. The final character of an accepted string holds the back
// end while it reads the 32-byte payload store one byte per cycle, unless
// the output stalls, through its single read port. The first result passes
// through the queue, the emit state, the registered store read and the
// output register. A rejected string's result passes through the queue,
// the read stage and the output register. During the readout the front
// end keeps taking characters until the two-entry queue between the halves
// is full. A rejected string needs no readout.
module bech32_key_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               char_valid,
	output logic               char_ready,
	input  bkd_pkg::in_item_t  char_item,
	output logic               res_valid,
	input  logic               res_ready,
	output bkd_pkg::out_item_t res_item
);

	// Front end to queue.
	logic            push_valid;
	logic            push_ready;
	bkd_pkg::entry_t push_entry;

	// Queue to back end.
	logic            pop_valid;
	logic            pop_ready;
	bkd_pkg::entry_t pop_entry;

	// Classify each character and track its position in the string.
	bkd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_item  (char_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry)
	);

	// Decouple the halves so the front can keep loading while results drain.
	bkd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_entry (push_entry),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_entry  (pop_entry)
	);

	// Run the checksum, regroup bits into the store and emit results.
	bkd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_entry (pop_entry),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

endmodule
